// ===== rtl/led_ring_status_cue_controller_unit_defines.svh =====
// Assertion macros shared by the LED ring status cue controller RTL.
// Define SYNTH to compile every check away; no other dependencies.
`ifndef LED_RING_STATUS_CUE_CONTROLLER_UNIT_DEFINES_SVH
`define LED_RING_STATUS_CUE_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTH
// Expression holds at every clock edge out of reset.
`define LRSC_CHECK(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define LRSC_CHECK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define LRSC_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LRSC_CHECK(label, clk, rst_n, expr, msg)
`define LRSC_CHECK_IMPL(label, clk, rst_n, ante, cons, msg)
`define LRSC_CHECK_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/lrsc_pkg.sv =====
// Shared types, codes and constants for the LED ring status cue controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lrsc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOW_MS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATTERY_PCT = 3'd4;

  localparam logic        RST_FEEDBACK_ENABLE = 1'b1;
  localparam logic [15:0] RST_GLOW_MS         = 16'd140;
  localparam logic [15:0] RST_FRAME_MS        = 16'd33;
  localparam logic [15:0] RST_BATTERY_PERIOD  = 16'd1000;
  localparam logic [6:0]  RST_LOW_BATTERY_PCT = 7'd20;

  // Cue timing and color constants
  localparam int BREATH_PERIOD_MS = 2000;
  localparam int COMET_STEP_MS    = 180;
  localparam int COMET_REACH_Q8   = 384;
  localparam int COMET_PEAK       = 14;
  localparam int DIV3_MUL         = 171;  // floor(x/3) = (x*171)>>9 for x < 64
  localparam int DIV3_SHIFT       = 9;
  localparam logic [5:0] BREATH_FLOOR = 6'd2;
  localparam logic [4:0] GLOW_LEVEL   = 5'd20;

  // Q30 angle constants for the breathing wave
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

  typedef enum logic [2:0] {
    ACT_APPLY     = 3'd0,
    ACT_ANIMATE   = 3'd1,
    ACT_SET_ALL   = 3'd2,
    ACT_SET_PIXEL = 3'd3,
    ACT_SHOW      = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_BASE   = 2'd0,
    MODE_GLOW   = 2'd1,
    MODE_LOW    = 2'd2,
    MODE_CHARGE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ROUTE_NONE,
    ROUTE_BASE,
    ROUTE_GLOW,
    ROUTE_LOW,
    ROUTE_CHARGE
  } route_t;

  typedef enum logic [1:0] {
    EMIT_BASE,
    EMIT_FILL,
    EMIT_PIXEL,
    EMIT_SHOW
  } emit_sel_t;

  // Steps of the time reduction: quotient, remainder, scale, quotient
  typedef enum logic [1:0] {
    RED_QUOT_NOW,
    RED_REM,
    RED_SCALE,
    RED_QUOT_POS
  } red_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BASE,
    ST_QUOT1,
    ST_REM,
    ST_SCALE,
    ST_QUOT2,
    ST_LOOK,
    ST_FILL,
    ST_PIXEL,
    ST_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        paused;
    logic        charging;
    logic        discharging;
    logic [6:0]  battery_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  pixel_index;
    logic [5:0]  red;
    logic [4:0]  green;
    logic [4:0]  blue;
    logic [31:0] base_time_ms;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    logic      decide;
    logic      red_en;
    red_op_t   red_op;
    logic      pix_clear;
    logic      pix_adv;
    logic      load_out;
    emit_sel_t emit_sel;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    route_t route;
    logic   is_low;
    logic   pix_last;
    logic   out_free;
  } dp_status_t;

endpackage

// ===== rtl/lrsc_ctrl.sv =====
// Sequencer for the LED ring status cue controller: walks one request
// through decide, reduce and emit steps. Depends on lrsc_pkg.
`timescale 1ns / 1ps
`include "led_ring_status_cue_controller_unit_defines.svh"

module lrsc_ctrl
  import lrsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_sel = EMIT_SHOW;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide    = 1'b1;
        cmd.pix_clear = 1'b1;
        unique case (sts.route)
          ROUTE_NONE:   state_nxt = ST_IDLE;
          ROUTE_BASE:   state_nxt = ST_BASE;
          ROUTE_GLOW:   state_nxt = ST_FILL;
          ROUTE_LOW:    state_nxt = ST_QUOT1;
          ROUTE_CHARGE: state_nxt = ST_QUOT1;
          default:      state_nxt = ST_IDLE;
        endcase
      end
      ST_BASE: begin
        cmd.emit_sel = EMIT_BASE;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_QUOT1: begin
        cmd.red_en = 1'b1;
        cmd.red_op = RED_QUOT_NOW;
        state_nxt  = ST_REM;
      end
      ST_REM: begin
        cmd.red_en = 1'b1;
        cmd.red_op = RED_REM;
        state_nxt  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.red_en = 1'b1;
        cmd.red_op = RED_SCALE;
        state_nxt  = ST_QUOT2;
      end
      ST_QUOT2: begin
        cmd.red_en = 1'b1;
        cmd.red_op = RED_QUOT_POS;
        state_nxt  = sts.is_low ? ST_LOOK : ST_PIXEL;
      end
      ST_LOOK: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.emit_sel = EMIT_FILL;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_SHOW;
        end
      end
      ST_PIXEL: begin
        cmd.emit_sel = EMIT_PIXEL;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.pix_adv  = 1'b1;
          if (sts.pix_last) begin
            state_nxt = ST_SHOW;
          end
        end
      end
      ST_SHOW: begin
        cmd.emit_sel = EMIT_SHOW;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LRSC_CHECK_IMPL(a_load_needs_room, clk, rst_n, cmd.load_out, sts.out_free, "result loaded into a full output register")
  `LRSC_CHECK_IMPL(a_idle_quiet, clk, rst_n, state_r == ST_IDLE, !cmd.load_out && !cmd.red_en, "work issued while idle")
  `LRSC_CHECK_NEXT(a_reduce_exit, clk, rst_n, state_r == ST_QUOT2, state_r == ST_LOOK || state_r == ST_PIXEL, "time reduction left to a wrong step")

endmodule

// ===== rtl/lrsc_dp.sv =====
// Datapath for the LED ring status cue controller: configuration and cue
// state, the reciprocal-multiply time reducer, wave table, comet shading and
// the output register. Depends on lrsc_pkg.
`timescale 1ns / 1ps
`include "led_ring_status_cue_controller_unit_defines.svh"

module lrsc_dp
  import lrsc_pkg::*;
#(
  parameter int RING_LEDS  = 12,
  parameter int WAVE_STEPS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int COMET_MS  = COMET_STEP_MS * RING_LEDS;
  localparam int SPAN      = RING_LEDS * 256;
  localparam int SPAN_W    = $clog2(SPAN + 1);
  localparam int PH_W      = $clog2(WAVE_STEPS);

  // floor(n/d) = (n*m) >> s for every n below 2^RECIP_N, with m < 2^31
  localparam int RECIP_N    = 30;
  localparam int BREATH_PRE = 4;  // 2000 = 16 * 125
  localparam int COMET_PRE  = 2;  // 180 = 4 * 45
  localparam int BREATH_DIV = BREATH_PERIOD_MS >> BREATH_PRE;
  localparam int COMET_DIV  = COMET_MS >> COMET_PRE;
  localparam int STEP_DIV   = COMET_STEP_MS >> COMET_PRE;

  function automatic logic [31:0] recip_f(input int d);
    logic [63:0] num;
    num = 64'd1 << (RECIP_N + $clog2(d));
    return 32'((num + 64'(d) - 64'd1) / 64'(d));
  endfunction

  localparam logic [31:0] M_BREATH = recip_f(BREATH_DIV);
  localparam logic [31:0] M_COMET  = recip_f(COMET_DIV);
  localparam logic [31:0] M_STEP   = recip_f(STEP_DIV);
  localparam int          S_BREATH = RECIP_N + $clog2(BREATH_DIV);
  localparam int          S_COMET  = RECIP_N + $clog2(COMET_DIV);
  localparam int          S_STEP   = RECIP_N + $clog2(STEP_DIV);

  // Breathing level for one wave phase, built at elaboration
  function automatic logic [5:0] breath_red_f(input int unsigned phase);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic        neg;
    a   = (Q30_TWO_PI * 64'(phase)) / WAVE_STEPS;
    neg = 1'b0;
    if (a >= Q30_PI) begin
      neg = 1'b1;
      a   = a - Q30_PI;
    end
    if (a > Q30_HALF_PI) begin
      a = Q30_PI - a;
    end
    x2   = (a * a) >> 30;
    sum  = a;
    term = ((a * x2) >> 30) / 6;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = (term > sum) ? 64'd0 : sum - term;
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    v = neg ? Q30_ONE - sum : Q30_ONE + sum;
    return 6'(64'(BREATH_FLOOR) + ((v * 64'd30) >> 31));
  endfunction

  logic [5:0] wave_rom [WAVE_STEPS];

  for (genvar g = 0; g < WAVE_STEPS; g++) begin : g_wave
    assign wave_rom[g] = breath_red_f(g);
  end

  // Configuration registers
  logic        fe_r;
  logic [15:0] glow_ms_r;
  logic [15:0] frame_ms_r;
  logic [15:0] bat_period_r;
  logic [6:0]  low_pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r         <= RST_FEEDBACK_ENABLE;
      glow_ms_r    <= RST_GLOW_MS;
      frame_ms_r   <= RST_FRAME_MS;
      bat_period_r <= RST_BATTERY_PERIOD;
      low_pct_r    <= RST_LOW_BATTERY_PCT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FEEDBACK_ENABLE: fe_r         <= cfg_data[0];
        CFG_GLOW_MS:         glow_ms_r    <= cfg_data;
        CFG_FRAME_MS:        frame_ms_r   <= cfg_data;
        CFG_BATTERY_PERIOD:  bat_period_r <= cfg_data;
        CFG_LOW_BATTERY_PCT: low_pct_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Capture the request
  in_item_t in_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  // Cue state
  logic [31:0] glow_deadline_r, glow_deadline_nxt;
  logic [31:0] bat_time_r, bat_time_nxt;
  logic [31:0] frame_time_r, frame_time_nxt;
  logic        chg_seen_r, chg_seen_nxt;
  logic        low_seen_r, low_seen_nxt;
  mode_t       cur_mode_r, cur_mode_nxt;
  logic        apply_r, apply_nxt;

  logic [31:0] bat_elapsed;
  logic [31:0] frame_elapsed;
  logic        sample;
  logic        chg_eff;
  logic        low_eff;
  logic        frame_wait;
  logic        changed;
  mode_t       mode_sel;
  route_t      route;

  // Pick the cue for a tick
  always_comb begin
    bat_elapsed   = in_r.now_ms - bat_time_r;
    frame_elapsed = in_r.now_ms - frame_time_r;
    sample        = bat_elapsed >= 32'(bat_period_r);
    chg_eff       = sample ? in_r.charging : chg_seen_r;
    low_eff       = sample ? (in_r.discharging && (in_r.battery_level <= low_pct_r))
                           : low_seen_r;
    frame_wait    = frame_elapsed < 32'(frame_ms_r);
    mode_sel      = MODE_BASE;
    if (fe_r && !in_r.paused) begin
      priority if (in_r.now_ms < glow_deadline_r) mode_sel = MODE_GLOW;
      else if (low_eff)                           mode_sel = MODE_LOW;
      else if (chg_eff)                           mode_sel = MODE_CHARGE;
      else                                        mode_sel = MODE_BASE;
    end
    changed = mode_sel != cur_mode_r;
    priority if (in_r.command)                         route = ROUTE_NONE;
    else if (mode_sel == MODE_BASE)                    route = in_r.paused ? ROUTE_NONE
                                                                           : ROUTE_BASE;
    else if (!changed && mode_sel == MODE_GLOW)        route = ROUTE_NONE;
    else if (!changed && frame_wait)                   route = ROUTE_NONE;
    else if (mode_sel == MODE_GLOW)                    route = ROUTE_GLOW;
    else if (mode_sel == MODE_LOW)                     route = ROUTE_LOW;
    else                                               route = ROUTE_CHARGE;
  end

  // Commit cue state at the decide step
  always_comb begin
    glow_deadline_nxt = glow_deadline_r;
    bat_time_nxt      = bat_time_r;
    frame_time_nxt    = frame_time_r;
    chg_seen_nxt      = chg_seen_r;
    low_seen_nxt      = low_seen_r;
    cur_mode_nxt      = cur_mode_r;
    apply_nxt         = apply_r;
    if (cmd.decide) begin
      if (in_r.command) begin
        if (fe_r) begin
          glow_deadline_nxt = in_r.now_ms + 32'(glow_ms_r);
        end
      end else begin
        if (sample) begin
          bat_time_nxt = in_r.now_ms;
          chg_seen_nxt = chg_eff;
          low_seen_nxt = low_eff;
        end
        cur_mode_nxt = mode_sel;
        apply_nxt    = cur_mode_r != MODE_BASE;
        if (route == ROUTE_GLOW || route == ROUTE_LOW || route == ROUTE_CHARGE) begin
          frame_time_nxt = in_r.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glow_deadline_r <= '0;
      bat_time_r      <= '0;
      frame_time_r    <= '0;
      chg_seen_r      <= 1'b0;
      low_seen_r      <= 1'b0;
      cur_mode_r      <= MODE_BASE;
      apply_r         <= 1'b0;
    end else begin
      glow_deadline_r <= glow_deadline_nxt;
      bat_time_r      <= bat_time_nxt;
      frame_time_r    <= frame_time_nxt;
      chg_seen_r      <= chg_seen_nxt;
      low_seen_r      <= low_seen_nxt;
      cur_mode_r      <= cur_mode_nxt;
      apply_r         <= apply_nxt;
    end
  end

  // Time reducer: one shared multiply per step, quotient ends up as phase or head
  logic        red_low;
  logic [31:0] val_r, val_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    red_low = cur_mode_r == MODE_LOW;
    mul_a   = '0;
    mul_b   = '0;
    unique case (cmd.red_op)
      RED_QUOT_NOW: begin
        mul_a = red_low ? (in_r.now_ms >> BREATH_PRE) : (in_r.now_ms >> COMET_PRE);
        mul_b = red_low ? M_BREATH : M_COMET;
      end
      RED_REM: begin
        mul_a = quot_r;
        mul_b = red_low ? 32'(BREATH_PERIOD_MS) : 32'(COMET_MS);
      end
      RED_SCALE: begin
        mul_a = val_r;
        mul_b = red_low ? 32'(WAVE_STEPS) : 32'd256;
      end
      RED_QUOT_POS: begin
        mul_a = red_low ? (val_r >> BREATH_PRE) : (val_r >> COMET_PRE);
        mul_b = red_low ? M_BREATH : M_STEP;
      end
      default: ;
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);

    val_nxt  = val_r;
    quot_nxt = quot_r;
    if (cmd.red_en) begin
      unique case (cmd.red_op)
        RED_QUOT_NOW: quot_nxt = red_low ? 32'(mul_p >> S_BREATH) : 32'(mul_p >> S_COMET);
        RED_REM:      val_nxt  = in_r.now_ms - mul_p[31:0];
        RED_SCALE:    val_nxt  = mul_p[31:0];
        RED_QUOT_POS: quot_nxt = red_low ? 32'(mul_p >> S_BREATH) : 32'(mul_p >> S_STEP);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    quot_r <= quot_nxt;
  end

  // Register the wave table read; the quotient is the phase
  logic [5:0] red_r;

  always_ff @(posedge clk) begin
    red_r <= wave_rom[quot_r[PH_W-1:0]];
  end

  // Pixel counter, held on the last pixel
  logic [5:0] pix_r, pix_nxt;
  logic       pix_last;

  always_comb begin
    pix_last = pix_r == 6'(RING_LEDS - 1);
    pix_nxt  = pix_r;
    if (cmd.pix_clear) begin
      pix_nxt = '0;
    end else if (cmd.pix_adv && !pix_last) begin
      pix_nxt = pix_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else begin
      pix_r <= pix_nxt;
    end
  end

  // Comet shade for the current pixel; the quotient is the head position in Q8
  logic [SPAN_W-1:0] comet_pos;
  logic [SPAN_W-1:0] pix_pos;
  logic [SPAN_W-1:0] dist_raw;
  logic [SPAN_W-1:0] dist_wrap;
  logic [SPAN_W-1:0] ring_dist;
  logic              near;
  logic [8:0]        reach_left;
  logic [12:0]       scaled;
  logic [13:0]       third;
  logic [4:0]        green;

  always_comb begin
    comet_pos  = quot_r[SPAN_W-1:0];
    pix_pos    = SPAN_W'({pix_r, 8'h00});
    dist_raw   = (pix_pos > comet_pos) ? pix_pos - comet_pos : comet_pos - pix_pos;
    dist_wrap  = SPAN_W'(SPAN) - dist_raw;
    ring_dist  = (dist_wrap < dist_raw) ? dist_wrap : dist_raw;
    near       = 32'(ring_dist) < 32'(COMET_REACH_Q8);
    reach_left = 9'(32'(COMET_REACH_Q8) - 32'(ring_dist));
    scaled     = 13'(reach_left) * 13'(COMET_PEAK);
    // divide by 384 as a shift by 7 then a divide by 3
    third      = 14'(scaled[12:7]) * 14'(DIV3_MUL);
    green      = near ? 5'(third >> DIV3_SHIFT) : 5'd0;
  end

  // Result mux
  out_item_t emit_item;

  always_comb begin
    emit_item = '0;
    unique case (cmd.emit_sel)
      EMIT_BASE: begin
        emit_item.action       = apply_r ? ACT_APPLY : ACT_ANIMATE;
        emit_item.base_time_ms = apply_r ? 32'd0 : in_r.now_ms;
        emit_item.last         = 1'b1;
      end
      EMIT_FILL: begin
        emit_item.action = ACT_SET_ALL;
        if (cur_mode_r == MODE_GLOW) begin
          emit_item.red   = 6'(GLOW_LEVEL);
          emit_item.green = GLOW_LEVEL;
          emit_item.blue  = GLOW_LEVEL;
        end else begin
          emit_item.red = red_r;
        end
      end
      EMIT_PIXEL: begin
        emit_item.action      = ACT_SET_PIXEL;
        emit_item.pixel_index = pix_r;
        emit_item.green       = green;
      end
      EMIT_SHOW: begin
        emit_item.action = ACT_SHOW;
        emit_item.last   = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.route    = route;
  assign sts.is_low   = cur_mode_r == MODE_LOW;
  assign sts.pix_last = pix_last;
  assign sts.out_free = !out_valid_r || out_ready;

  `LRSC_CHECK(a_pix_in_ring, clk, rst_n, 32'(pix_r) < 32'(RING_LEDS), "pixel counter ran past the ring")
  `LRSC_CHECK_IMPL(a_green_peak, clk, rst_n, out_valid_r && out_data_r.action == ACT_SET_PIXEL, out_data_r.green <= 5'(COMET_PEAK), "comet shade above its peak")
  `LRSC_CHECK_NEXT(a_head_in_range, clk, rst_n, cmd.red_en && cmd.red_op == RED_QUOT_POS, quot_r < (sts.is_low ? 32'(WAVE_STEPS) : 32'(SPAN)), "wave phase or comet head out of range")

endmodule

// ===== rtl/led_ring_status_cue_controller_unit.sv =====
// Channel   Handshake              Payload            Direction
// in        in_valid / in_ready    in_data (in_item_t)  button presses and ticks in
// out       out_valid / out_ready  out_data (out_item_t) LED commands out
// cfg       cfg_we                 cfg_index, cfg_data  register writes in
//
// One request at a time. A press, or a tick that emits nothing, ends at the decide
// step. A base frame emits one command, a glow frame a fill and a show. Low battery
// and charging frames first reduce the time in four single-multiply steps; low
// battery then reads the wave table for a fill and a show, charging emits one pixel
// per LED and a show. Reset is synchronous, active low, and needs no clearing pass;
// output stalls hold the sequencer in its emit step, one result register deep.
`timescale 1ns / 1ps

module led_ring_status_cue_controller_unit
  import lrsc_pkg::*;
#(
  parameter int RING_LEDS  = 12,
  parameter int WAVE_STEPS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer
  lrsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  lrsc_dp #(
    .RING_LEDS  (RING_LEDS),
    .WAVE_STEPS (WAVE_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/led_ring_status_cue_controller_unit_test.sv =====
// Self-checking testbench for the LED ring status cue controller.
// Drives presses and ticks, predicts every LED command, compares in order.
// Depends on lrsc_pkg and the led_ring_status_cue_controller_unit RTL only.
`timescale 1ns / 1ps

module led_ring_status_cue_controller_unit_test;
  import lrsc_pkg::*;

  localparam int LEDS = 12;
  localparam int WAVE = 256;
  localparam int BREATH_SPAN = 30;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SESSIONS = 6;
  localparam int SESSION_ITEMS = 70;
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PRESS = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the settings
  logic fb_enable = RST_FEEDBACK_ENABLE;
  logic [15:0] glow_len_ms = RST_GLOW_MS;
  logic [15:0] frame_gap_ms = RST_FRAME_MS;
  logic [15:0] sample_period_ms = RST_BATTERY_PERIOD;
  logic [6:0] low_pct = RST_LOW_BATTERY_PCT;

  // Predictor copy of the cue state
  logic [31:0] glow_until = '0;
  logic [31:0] sample_stamp = '0;
  logic [31:0] frame_stamp = '0;
  logic chg_seen = 1'b0;
  logic low_seen = 1'b0;
  mode_t cue_mode = MODE_BASE;

  out_item_t cmds_due[$];
  logic steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned writes_done = 0;
  int unsigned cycles = 0;

  led_ring_status_cue_controller_unit #(
    .RING_LEDS(LEDS),
    .WAVE_STEPS(WAVE)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_cmd(action_t act, int unsigned pix, int unsigned r,
                                   int unsigned g, int unsigned b, logic [31:0] t,
                                   logic fin);
    out_item_t c;
    c.action = act;
    c.pixel_index = 6'(pix);
    c.red = 6'(r);
    c.green = 5'(g);
    c.blue = 5'(b);
    c.base_time_ms = t;
    c.last = fin;
    cmds_due.push_back(c);
  endfunction

  // Work out the LED commands one accepted request causes
  function automatic void predict_led_cmds(in_item_t it);
    mode_t want_mode;
    logic [63:0] phase, ang, x2, term, sum, v;
    logic neg;
    int unsigned pos, d, g, span;
    if (it.command == CMD_PRESS) begin
      if (fb_enable) glow_until = it.now_ms + 32'(glow_len_ms);
      return;
    end
    // Resample the battery once the period has run out
    if (32'(it.now_ms - sample_stamp) >= 32'(sample_period_ms)) begin
      sample_stamp = it.now_ms;
      chg_seen = it.charging;
      low_seen = it.discharging && (it.battery_level <= low_pct);
    end
    want_mode = MODE_BASE;
    if (fb_enable && !it.paused) begin
      if (it.now_ms < glow_until) want_mode = MODE_GLOW;
      else if (low_seen) want_mode = MODE_LOW;
      else if (chg_seen) want_mode = MODE_CHARGE;
    end
    // Hand the ring back to the user setting
    if (want_mode == MODE_BASE) begin
      if (!it.paused) begin
        if (cue_mode != MODE_BASE) push_cmd(ACT_APPLY, 0, 0, 0, 0, '0, 1'b1);
        else push_cmd(ACT_ANIMATE, 0, 0, 0, 0, it.now_ms, 1'b1);
      end
      cue_mode = MODE_BASE;
      return;
    end
    // Drop repeated glow and frames that come too soon
    if (want_mode == cue_mode) begin
      if (want_mode == MODE_GLOW) return;
      if (32'(it.now_ms - frame_stamp) < 32'(frame_gap_ms)) return;
    end
    cue_mode = want_mode;
    frame_stamp = it.now_ms;
    case (want_mode)
      MODE_GLOW: begin
        push_cmd(ACT_SET_ALL, 0, GLOW_LEVEL, GLOW_LEVEL, GLOW_LEVEL, '0, 1'b0);
      end
      MODE_LOW: begin
        // Sine by folded Taylor series in Q30, then scale into the red span
        phase = (64'(it.now_ms % BREATH_PERIOD_MS) * WAVE) / BREATH_PERIOD_MS;
        ang = (Q30_TWO_PI * (phase % WAVE)) / WAVE;
        neg = 1'b0;
        if (ang >= Q30_PI) begin
          neg = 1'b1;
          ang = ang - Q30_PI;
        end
        if (ang > Q30_HALF_PI) ang = Q30_PI - ang;
        x2 = (ang * ang) >> 30;
        term = ang;
        sum = ang;
        for (int n = 1; n <= 5; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
          else sum = sum + term;
        end
        if (sum > Q30_ONE) sum = Q30_ONE;
        v = neg ? Q30_ONE - sum : Q30_ONE + sum;
        push_cmd(ACT_SET_ALL, 0, BREATH_FLOOR + 32'((v * BREATH_SPAN) >> 31), 0, 0,
                 '0, 1'b0);
      end
      default: begin
        // Comet head in Q8, green falls off with ring distance
        span = LEDS * 256;
        pos = ((it.now_ms % (COMET_STEP_MS * LEDS)) * 256) / COMET_STEP_MS;
        for (int i = 0; i < LEDS; i++) begin
          d = (i * 256 > pos) ? i * 256 - pos : pos - i * 256;
          if (span - d < d) d = span - d;
          g = (d < COMET_REACH_Q8) ? ((COMET_REACH_Q8 - d) * COMET_PEAK) / COMET_REACH_Q8 : 0;
          push_cmd(ACT_SET_PIXEL, i, 0, g, 0, '0, 1'b0);
        end
      end
    endcase
    push_cmd(ACT_SHOW, 0, 0, 0, 0, '0, 1'b1);
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [31:0] now, logic pz,
                                         logic chg, logic dis, logic [6:0] lvl);
    in_item_t it;
    it.command = cmd;
    it.now_ms = now;
    it.paused = pz;
    it.charging = chg;
    it.discharging = dis;
    it.battery_level = lvl;
    return it;
  endfunction

  function automatic logic [15:0] draw_setting(logic [15:0] top, int unsigned typical);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return top;
    return 16'($urandom_range(0, typical));
  endfunction

  // Send one request, idling first for a random number of cycles
  task automatic send_request(in_item_t item);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_led_cmds(item);
    requests_sent++;
  endtask

  // Drop valid, wait for every expected command, then let silent work finish
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cmds_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FEEDBACK_ENABLE: fb_enable = data[0];
      CFG_GLOW_MS: glow_len_ms = data;
      CFG_FRAME_MS: frame_gap_ms = data;
      CFG_BATTERY_PERIOD: sample_period_ms = data;
      CFG_LOW_BATTERY_PCT: low_pct = data[6:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Walk every cue, its priority and the glow deadline wrap under reset settings
  task automatic test_cue_priority();
    send_request(make_item(CMD_TICK, 32'd10, 0, 0, 0, 7'd50));
    send_request(make_item(CMD_PRESS, 32'd20, 0, 0, 0, 7'd0));
    send_request(make_item(CMD_TICK, 32'd30, 0, 0, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd40, 0, 0, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd1000, 0, 1, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd1010, 0, 1, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd1043, 0, 1, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd1050, 1, 1, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd1060, 0, 1, 0, 7'd50));
    send_request(make_item(CMD_TICK, 32'd2100, 0, 0, 1, 7'd20));
    send_request(make_item(CMD_TICK, 32'd2140, 0, 0, 1, 7'd20));
    send_request(make_item(CMD_PRESS, 32'd2150, 0, 0, 1, 7'd20));
    send_request(make_item(CMD_TICK, 32'd2160, 0, 0, 1, 7'd20));
    // Glow runs out while paused: nothing is applied
    send_request(make_item(CMD_TICK, 32'd2300, 1, 0, 1, 7'd20));
    send_request(make_item(CMD_TICK, 32'd2310, 0, 0, 1, 7'd20));
    send_request(make_item(CMD_TICK, 32'd3200, 0, 0, 1, 7'd21));
    send_request(make_item(CMD_TICK, 32'd3210, 0, 0, 1, 7'd21));
    // Deadline wraps past zero and the plain compare misses it
    send_request(make_item(CMD_PRESS, 32'hFFFF_FF80, 1, 1, 1, 7'd127));
    send_request(make_item(CMD_TICK, 32'hFFFF_FFA0, 0, 0, 1, 7'd127));
    send_request(make_item(CMD_TICK, 32'h0000_0005, 0, 0, 1, 7'd127));
  endtask

  // Push every register to its extremes, unused indexes included
  task automatic test_setting_extremes();
    settle_block();
    write_reg(CFG_FEEDBACK_ENABLE, 16'hFFFE);
    for (int i = CFG_UNUSED_FIRST; i < (1 << CFG_IDX_W); i++) write_reg(CFG_IDX_W'(i), 16'hFFFF);
    send_request(make_item(CMD_PRESS, 32'd4000, 0, 0, 0, 7'd0));
    send_request(make_item(CMD_TICK, 32'd4010, 0, 1, 0, 7'd0));
    settle_block();
    write_reg(CFG_FEEDBACK_ENABLE, 16'h0001);
    write_reg(CFG_BATTERY_PERIOD, 16'd0);
    write_reg(CFG_FRAME_MS, 16'd0);
    write_reg(CFG_LOW_BATTERY_PCT, 16'hFF7F);
    send_request(make_item(CMD_TICK, 32'd4020, 0, 0, 1, 7'd127));
    send_request(make_item(CMD_TICK, 32'd4020, 0, 0, 1, 7'd127));
    settle_block();
    write_reg(CFG_LOW_BATTERY_PCT, 16'd0);
    write_reg(CFG_FRAME_MS, 16'hFFFF);
    write_reg(CFG_GLOW_MS, 16'hFFFF);
    send_request(make_item(CMD_TICK, 32'd4030, 0, 0, 1, 7'd0));
    send_request(make_item(CMD_TICK, 32'd4040, 0, 1, 0, 7'd1));
    send_request(make_item(CMD_PRESS, 32'd4050, 0, 0, 0, 7'd0));
    send_request(make_item(CMD_TICK, 32'd4060, 0, 1, 0, 7'd0));
    settle_block();
    write_reg(CFG_GLOW_MS, 16'd0);
    send_request(make_item(CMD_PRESS, 32'd4070, 0, 0, 0, 7'd0));
    send_request(make_item(CMD_TICK, 32'd4070, 0, 1, 0, 7'd0));
    settle_block();
    write_reg(CFG_BATTERY_PERIOD, 16'hFFFF);
    write_reg(CFG_LOW_BATTERY_PCT, 16'd100);
    send_request(make_item(CMD_TICK, 32'd4080, 0, 0, 1, 7'd100));
    settle_block();
    write_reg(CFG_BATTERY_PERIOD, 16'd1);
    send_request(make_item(CMD_TICK, 32'd4090, 0, 0, 1, 7'd100));
  endtask

  // Sessions of advancing time with random settings, battery changes and noise
  task automatic test_random_sessions();
    logic [31:0] t;
    logic chg, dis, pz;
    logic [6:0] lvl;
    int unsigned r;
    in_item_t it;
    for (int s = 0; s < SESSIONS; s++) begin
      settle_block();
      write_reg(CFG_FEEDBACK_ENABLE, {15'($urandom), 1'($urandom_range(0, 5) != 0)});
      write_reg(CFG_GLOW_MS, draw_setting(16'hFFFF, 300));
      write_reg(CFG_FRAME_MS, draw_setting(16'hFFFF, 80));
      write_reg(CFG_BATTERY_PERIOD, draw_setting(16'hFFFF, 1500));
      write_reg(CFG_LOW_BATTERY_PCT, {9'($urandom), 7'(draw_setting(16'd127, 100))});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, (1 << CFG_IDX_W) - 1)),
                  16'($urandom));
      end
      t = (s == 1) ? 32'hFFFF_F000 : $urandom;
      chg = 1'($urandom);
      dis = 1'($urandom);
      lvl = 7'($urandom_range(0, 100));
      pz = 1'b0;
      for (int k = 0; k < SESSION_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // Noise: any field value at all
          it = make_item(1'($urandom), $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                         7'($urandom));
        end else if (r < 18) begin
          it = make_item(CMD_PRESS, t, 1'($urandom), 1'($urandom), 1'($urandom),
                         7'($urandom));
        end else begin
          t = t + ((r < 24) ? $urandom_range(200, 2500) : $urandom_range(0, 60));
          if ($urandom_range(0, 9) == 0) begin
            chg = 1'($urandom);
            dis = 1'($urandom);
            lvl = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
          end
          if ($urandom_range(0, 11) == 0) pz = !pz;
          it = make_item(CMD_TICK, t, pz, chg, dis, lvl);
        end
        send_request(it);
      end
    end
  endtask

  // Hold the result side off for a random number of cycles per command
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted command with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (cmds_due.size() == 0) begin
        $error("unexpected LED command, action %0d", out_data.action);
        errors++;
      end else begin
        want = cmds_due.pop_front();
        if (out_data.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_data.action);
          errors++;
        end
        if (out_data.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index, out_data.pixel_index);
          errors++;
        end
        if (out_data.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_data.red);
          errors++;
        end
        if (out_data.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_data.green);
          errors++;
        end
        if (out_data.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
          errors++;
        end
        if (out_data.base_time_ms !== want.base_time_ms) begin
          $error("base_time_ms: expected %0d, got %0d", want.base_time_ms,
                 out_data.base_time_ms);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
      stall_left = steady ? 0 : $urandom_range(0, 19);
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_cue_priority();
    test_setting_extremes();
    test_random_sessions();
    settle_block();
    $display("Sent %0d requests and %0d register writes; checked %0d LED commands in %0d cycles",
             requests_sent, writes_done, results_seen, cycles);
    $display("Covered glow, low battery, charging and base cues with random gaps and stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== led_ring_status_cue_controller_unit.f =====
+incdir+rtl
rtl/lrsc_pkg.sv
rtl/lrsc_ctrl.sv
rtl/lrsc_dp.sv
rtl/led_ring_status_cue_controller_unit.sv
tb/led_ring_status_cue_controller_unit_test.sv
